/* hdl/kvt_pkg.sv */
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants for the key/value table: request and response
// words, field widths and request codes.
// ----------------------------------------------------------------------------
package kvt_pkg;

   // default number of table slots
   localparam int ENTRIES_DEFAULT = 64;

   // field widths
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CNT_W = 7;

   // request codes
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // request word
   typedef struct packed {
      logic                    req_type;
      logic [KEY_W-1:0]        key;
      logic signed [VAL_W-1:0] write_value;
   } req_word_type;

   // response word
   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic                    hit;
      logic [CNT_W-1:0]        entry_count;
      logic                    table_full;
   } rsp_word_type;

endpackage

/* hdl/kvt_ram.sv */
// ----------------------------------------------------------------------------
// kvt_ram
// Generic single-write, single-read synchronous RAM with a registered read
// port. Contents are undefined until written.
// ----------------------------------------------------------------------------
module kvt_ram #(
   parameter int WIDTH = kvt_pkg::KEY_W,
   parameter int DEPTH = kvt_pkg::ENTRIES_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]      wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]      rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);
   import kvt_pkg::*;

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/kvt_ctrl.sv */
// ----------------------------------------------------------------------------
// kvt_ctrl
// Lookup sequencer: scans the key store one slot per cycle up to the entry
// count, then on a write updates the value store or appends a new entry,
// and builds the response word.
// ----------------------------------------------------------------------------
module kvt_ctrl #(
   parameter int ENTRIES = kvt_pkg::ENTRIES_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   // request side
   input  logic                                          req_valid,
   output logic                                          req_stall,
   input  kvt_pkg::req_word_type                         req_data,
   // memory side
   output logic [$clog2(ENTRIES > 1 ? ENTRIES : 2)-1:0]  mem_raddr,
   input  logic [kvt_pkg::KEY_W-1:0]                     key_rdata,
   input  logic [kvt_pkg::VAL_W-1:0]                     val_rdata,
   output logic                                          key_we,
   output logic                                          val_we,
   output logic [$clog2(ENTRIES > 1 ? ENTRIES : 2)-1:0]  mem_waddr,
   output logic [kvt_pkg::KEY_W-1:0]                     key_wdata,
   output logic [kvt_pkg::VAL_W-1:0]                     val_wdata,
   // response side
   output logic                                          res_valid,
   input  logic                                          res_ready,
   output kvt_pkg::rsp_word_type                         res_data
);
   import kvt_pkg::*;

   localparam int AW = $clog2(ENTRIES > 1 ? ENTRIES : 2);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_MISS,
      S_DONE
   } state_type;

   state_type    state_ff,  state_in;
   req_word_type req_ff,    req_in;
   logic [AW-1:0] idx_ff,   idx_in;
   logic [CW-1:0] count_ff, count_in;
   rsp_word_type res_ff,    res_in;

   // next state, memory accesses and response build
   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      res_in    = res_ff;
      mem_raddr = '0;
      key_we    = 1'b0;
      val_we    = 1'b0;
      mem_waddr = idx_ff;
      key_wdata = req_ff.key;
      val_wdata = req_ff.write_value;

      case (state_ff)
         S_IDLE: begin
            // first read goes out with the accept
            if (req_valid) begin
               req_in = req_data;
               idx_in = '0;
               if (count_ff == '0) begin
                  state_in = S_MISS;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // data for slot idx is on the read port, next slot requested
            mem_raddr = idx_ff + AW'(1);
            if (key_rdata == req_ff.key) begin
               res_in.hit         = 1'b1;
               res_in.table_full  = 1'b0;
               res_in.entry_count = CNT_W'(count_ff);
               if (req_ff.req_type == REQ_READ) begin
                  res_in.read_value = $signed(val_rdata);
               end else begin
                  res_in.read_value = '0;
                  val_we            = 1'b1;
                  mem_waddr         = idx_ff;
               end
               state_in = S_DONE;
            end else if (CW'(idx_ff) + CW'(1) == count_ff) begin
               state_in = S_MISS;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_MISS: begin
            // key absent: append on a write if there is room
            res_in.hit        = 1'b0;
            res_in.read_value = '0;
            res_in.table_full = 1'b0;
            res_in.entry_count = CNT_W'(count_ff);
            if (req_ff.req_type == REQ_WRITE) begin
               if (count_ff < FULL_COUNT) begin
                  key_we             = 1'b1;
                  val_we             = 1'b1;
                  mem_waddr          = count_ff[AW-1:0];
                  count_in           = count_ff + CW'(1);
                  res_in.entry_count = CNT_W'(count_ff + CW'(1));
               end else begin
                  res_in.table_full = 1'b1;
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      req_ff <= req_in;
      idx_ff <= idx_in;
      res_ff <= res_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res_data  = res_ff;

endmodule

/* hdl/key_value_table.sv */
// ----------------------------------------------------------------------------
// key_value_table
// Bounded associative table of unique 32-bit keys holding signed 32-bit
// values. Keys and values live in two synchronous RAMs scanned in order.
// ----------------------------------------------------------------------------
// requests: one word at a time; the next is accepted only once the response
//    word has gone to the output register, and a lookup's length is set by
//    the one-slot-per-cycle key scan
// reset: entry count and handshake state cleared at once, RAMs left as is
module key_value_table #(
   parameter int ENTRIES = kvt_pkg::ENTRIES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  kvt_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output kvt_pkg::rsp_word_type rsp_data
);
   import kvt_pkg::*;

   localparam int AW = $clog2(ENTRIES > 1 ? ENTRIES : 2);

   logic [AW-1:0]    mem_raddr;
   logic [AW-1:0]    mem_waddr;
   logic [KEY_W-1:0] key_rdata;
   logic [VAL_W-1:0] val_rdata;
   logic             key_we;
   logic             val_we;
   logic [KEY_W-1:0] key_wdata;
   logic [VAL_W-1:0] val_wdata;
   logic             res_valid;
   logic             res_ready;
   rsp_word_type     res_data;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_data_ff,  rsp_data_in;

   // key store
   kvt_ram #(
      .WIDTH (KEY_W),
      .DEPTH (ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (mem_waddr),
      .wr_data (key_wdata),
      .rd_addr (mem_raddr),
      .rd_data (key_rdata)
   );

   // value store
   kvt_ram #(
      .WIDTH (VAL_W),
      .DEPTH (ENTRIES)
   ) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (mem_waddr),
      .wr_data (val_wdata),
      .rd_addr (mem_raddr),
      .rd_data (val_rdata)
   );

   // scan sequencer
   kvt_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .mem_raddr (mem_raddr),
      .key_rdata (key_rdata),
      .val_rdata (val_rdata),
      .key_we    (key_we),
      .val_we    (val_we),
      .mem_waddr (mem_waddr),
      .key_wdata (key_wdata),
      .val_wdata (val_wdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   // output word register, refilled as soon as the held word is taken
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a new key always goes in with its value
   assert property (@(posedge clock) disable iff (reset)
      key_we |-> val_we)
      else $error("key written without value");

   // one word in flight: the request side closes right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a lookup is running");

   // a dropped write is never a hit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.table_full && rsp_data.hit))
      else $error("table full flagged on a hit");

   // a dropped write only happens with every slot in use
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.table_full) |-> (rsp_data.entry_count == CNT_W'(ENTRIES)))
      else $error("table full flagged below capacity");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for key_value_table. Requests are sent one word at a
// time, and a shadow copy of the table predicts each response word as its
// request is accepted. A separate process takes the response words and
// checks them in order. Both sides idle and stall at random. The table is
// never cleared, so the tests run from an empty table through growth to a
// full table.
// ----------------------------------------------------------------------------
module testbench;
   import kvt_pkg::*;

   localparam int SLOTS       = ENTRIES_DEFAULT;
   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = SLOTS + 8;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;

   // shadow copy of the table
   logic [KEY_W-1:0]        shadow_keys   [SLOTS];
   logic signed [VAL_W-1:0] shadow_values [SLOTS];
   int                      shadow_count = 0;

   // predicted response words, oldest first
   rsp_word_type pending_lookups [$];

   int fail_count    = 0;
   int words_sent    = 0;
   int words_checked = 0;
   int read_hits     = 0;
   int read_misses   = 0;
   int inserts       = 0;
   int replaces      = 0;
   int drops         = 0;
   int idle_cycles   = 0;

   // when set, a side runs with no idling
   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;

   key_value_table #(
      .ENTRIES (SLOTS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // apply one request to the shadow table and work out its response word
   function automatic rsp_word_type apply_to_shadow_table(input req_word_type w);
      rsp_word_type r;
      int           slot;
      int           i;
      r    = '0;
      slot = -1;
      for (i = 0; i < shadow_count; i++) begin
         if (slot < 0 && shadow_keys[i] == w.key) slot = i;
      end
      r.hit = (slot >= 0);
      if (w.req_type == REQ_READ) begin
         if (slot >= 0) begin
            r.read_value = shadow_values[slot];
            read_hits++;
         end else begin
            read_misses++;
         end
      end else if (slot >= 0) begin
         shadow_values[slot] = w.write_value;
         replaces++;
      end else if (shadow_count < SLOTS) begin
         shadow_keys[shadow_count]   = w.key;
         shadow_values[shadow_count] = w.write_value;
         shadow_count++;
         inserts++;
      end else begin
         // new key into a full table is dropped
         r.table_full = 1'b1;
         drops++;
      end
      r.entry_count = CNT_W'(shadow_count);
      return r;
   endfunction

   function automatic int draw_wait(input bit calm);
      if (calm || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 13);
   endfunction

   function automatic req_word_type make_word(input logic t, input logic [KEY_W-1:0] k,
                                              input logic [VAL_W-1:0] v);
      req_word_type w;
      w.req_type    = t;
      w.key         = k;
      w.write_value = v;
      return w;
   endfunction

   // a key already in the table, or a fresh random one
   function automatic logic [KEY_W-1:0] pick_key(input int fresh_pct);
      if (shadow_count == 0 || $urandom_range(0, 99) < fresh_pct) return $urandom;
      return shadow_keys[$urandom_range(0, shadow_count - 1)];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("word %0d %s got %h expected %h",
                                   words_checked, name, got, want));
   endtask

   task automatic check_response(input rsp_word_type got);
      rsp_word_type want;
      if (pending_lookups.size() == 0) begin
         report_mismatch("response word with no request outstanding");
      end else begin
         want = pending_lookups.pop_front();
         check_field("read_value", got.read_value, want.read_value);
         check_field("hit", got.hit, want.hit);
         check_field("entry_count", got.entry_count, want.entry_count);
         check_field("table_full", got.table_full, want.table_full);
      end
      words_checked++;
   endtask

   // send one request word, predicting its response on accept
   task automatic send_word(input req_word_type w);
      int gap;
      gap = draw_wait(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      pending_lookups.push_back(apply_to_shadow_table(w));
      words_sent++;
   endtask

   task automatic send_random(input int count, input int fresh_pct);
      int n;
      for (n = 0; n < count; n++) begin
         send_word(make_word($urandom_range(0, 1) ? REQ_READ : REQ_WRITE,
                             pick_key(fresh_pct), $urandom));
      end
   endtask

   // hold requests back until every response has come
   task automatic drain_requests();
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
   endtask

   // extremes of key and value, hits, misses, replace, zero value stored
   task automatic test_directed();
      send_word(make_word(REQ_READ,  32'h0000_0000, 32'h0000_0000));
      send_word(make_word(REQ_WRITE, 32'h0000_0000, 32'h8000_0000));
      send_word(make_word(REQ_WRITE, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
      send_word(make_word(REQ_READ,  32'h0000_0000, 32'h0000_0000));
      send_word(make_word(REQ_READ,  32'hFFFF_FFFF, 32'h0000_0000));
      send_word(make_word(REQ_WRITE, 32'h0000_0000, 32'hFFFF_FFFF));
      send_word(make_word(REQ_READ,  32'h0000_0000, 32'h0000_0000));
      send_word(make_word(REQ_WRITE, 32'h8000_0000, 32'h0000_0000));
      send_word(make_word(REQ_READ,  32'h8000_0000, 32'h1234_5678));
      send_word(make_word(REQ_READ,  32'h7FFF_FFFF, 32'h0000_0000));
      send_word(make_word(REQ_READ,  32'h0000_0001, 32'hFFFF_FFFF));
      send_word(make_word(REQ_WRITE, 32'h0000_0001, 32'h0000_0001));
      send_word(make_word(REQ_READ,  32'h0000_0001, 32'hFFFF_FFFF));
      send_word(make_word(REQ_WRITE, 32'h7FFF_FFFF, 32'h5555_5555));
      send_word(make_word(REQ_WRITE, 32'h5555_5555, 32'hAAAA_AAAA));
      send_word(make_word(REQ_READ,  32'hAAAA_AAAA, 32'h0000_0000));
      send_word(make_word(REQ_READ,  32'h5555_5555, 32'h0000_0000));
      send_word(make_word(REQ_READ,  32'h7FFF_FFFF, 32'h0000_0000));
   endtask

   // mixed traffic while the table slowly fills
   task automatic test_grow();
      tx_calm = 1'b1;
      rx_calm = 1'b1;
      send_random(100, 15);
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      send_random(600, 15);
   endtask

   // sender pauses until the pipe is empty, then restarts
   task automatic test_drained_restart();
      int n;
      for (n = 0; n < 5; n++) begin
         drain_requests();
         send_random(4, 50);
      end
   endtask

   // fill every slot, then drop writes of new keys, replace and read on the full table
   task automatic test_fill();
      while (shadow_count < SLOTS) send_word(make_word(REQ_WRITE, $urandom, $urandom));
      send_word(make_word(REQ_WRITE, $urandom, $urandom));
      send_word(make_word(REQ_WRITE, $urandom, $urandom));
      send_word(make_word(REQ_WRITE, shadow_keys[SLOTS-1], $urandom));
      send_word(make_word(REQ_READ,  shadow_keys[SLOTS-1], $urandom));
      send_word(make_word(REQ_READ,  shadow_keys[0], $urandom));
      send_word(make_word(REQ_READ,  $urandom, $urandom));
   endtask

   // traffic on a full table, idling on one side, then the other, then both
   task automatic test_full_random();
      rx_calm = 1'b1;
      send_random(300, 30);
      rx_calm = 1'b0;
      tx_calm = 1'b1;
      send_random(300, 30);
      tx_calm = 1'b0;
      send_random(400, 30);
   endtask

   // response side: random stall, then take one word and check it
   initial begin
      int n;
      wait (!reset);
      forever begin
         n = draw_wait(rx_calm);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         check_response(rsp_data);
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // test sequence
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_grow();
      test_drained_restart();
      test_fill();
      test_full_random();
      drain_requests();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d requests, %0d responses checked, %0d mismatches",
               words_sent, words_checked, fail_count);
      $display("reads: %0d hit %0d miss; writes: %0d new %0d replaced %0d dropped",
               read_hits, read_misses, inserts, replaces, drops);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
